@@ rtl/life_grid_generation_engine_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Life grid engine assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_ENGINE_UNIT_DEFINES_SVH
`define LIFE_GRID_GENERATION_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LGE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("life grid engine assertion failed");
// next-cycle implication
`define LGE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("life grid engine assertion failed");
`else
`define LGE_ASSERT_IMP(lbl, ante, cons)
`define LGE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/lge_pkg.sv @@
// ----------------------------------------------------------------------------
// Life grid engine package
// Request codes, field widths, rule constants and sequencer states.
// ----------------------------------------------------------------------------
package lge_pkg;

  localparam int REQ_TYPE_W  = 2;
  localparam int CELL_POS_W  = 5;
  localparam int NBR_CNT_W   = 4;

  localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_GEN   = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

  // B3/S23
  localparam logic [NBR_CNT_W-1:0] NBR_BIRTH = 4'd3;
  localparam logic [NBR_CNT_W-1:0] NBR_KEEP  = 4'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_UPD,
    ST_GEN,
    ST_DONE
  } state_t;

endpackage

@@ rtl/life_grid_generation_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Life grid generation engine
// Grid of one-bit cells with cell write, cell read and B3/S23 generation step.
// ----------------------------------------------------------------------------
// The grid sits in a single-port-write, registered-read row memory. After
// reset a clearing pass zeroes it, one row per cycle; no request is taken
// until it ends. A cell write or read passes through accept, row fetch, row
// update and result load. A generation streams the rows through one row-update
// unit with two row buffers, one row read and one row written per cycle,
// between accept and result load. An unused request code passes through
// accept and result load only. Requests are taken one at a time; the result
// register lets the next request in while a result waits to be taken, and
// the result load of that next request waits until the held result is taken.
`include "life_grid_generation_engine_unit_defines.svh"

module life_grid_generation_engine_unit #(
  parameter int GRID_ROWS = 32,
  parameter int GRID_COLS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [lge_pkg::REQ_TYPE_W-1:0] req_type,
  input  logic [lge_pkg::CELL_POS_W-1:0] cell_row,
  input  logic [lge_pkg::CELL_POS_W-1:0] cell_col,
  input  logic                           cell_value,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic                           read_value,
  output logic [lge_pkg::REQ_TYPE_W-1:0] completed_type
);

  import lge_pkg::*;

  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int CNT_W = $clog2(GRID_ROWS + 2);

  typedef logic [GRID_COLS-1:0] row_t;

  row_t             grid_mem [GRID_ROWS];
  row_t             rd_data;
  logic [ROW_W-1:0] rd_addr;
  logic             wr_en;
  logic [ROW_W-1:0] wr_addr;
  row_t             wr_data;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] gen_row;

  logic [REQ_TYPE_W-1:0] req_type_q;
  logic [CELL_POS_W-1:0] row_q;
  logic [CELL_POS_W-1:0] col_q;
  logic                  val_q;
  logic                  rd_bit;

  row_t above, cur, below, next_row;
  row_t cell_mask, cell_shift, cell_row_new;
  logic cell_inside;
  logic accept, rsp_free;

  assign accept   = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign gen_row  = cnt - CNT_W'(2);

  // row update unit
  function automatic row_t life_row(input row_t a, input row_t c, input row_t b);
    logic [GRID_COLS+1:0]  pa, pc, pb;
    logic [NBR_CNT_W-1:0]  s;
    row_t                  res;
    pa = {1'b0, a, 1'b0};
    pc = {1'b0, c, 1'b0};
    pb = {1'b0, b, 1'b0};
    for (int i = 0; i < GRID_COLS; i++) begin
      s = NBR_CNT_W'(pa[i]) + NBR_CNT_W'(pa[i+1]) + NBR_CNT_W'(pa[i+2])
        + NBR_CNT_W'(pc[i]) + NBR_CNT_W'(pc[i+2])
        + NBR_CNT_W'(pb[i]) + NBR_CNT_W'(pb[i+1]) + NBR_CNT_W'(pb[i+2]);
      res[i] = (s == NBR_BIRTH) || (pc[i+1] && (s == NBR_KEEP));
    end
    return res;
  endfunction

  assign below    = (cnt <= CNT_W'(GRID_ROWS)) ? rd_data : '0;
  assign next_row = life_row(above, cur, below);

  assign cell_inside  = ({27'd0, row_q} < 32'(GRID_ROWS)) &&
                        ({27'd0, col_q} < 32'(GRID_COLS));
  assign cell_mask    = row_t'(1) << col_q;
  assign cell_shift   = rd_data >> col_q;
  assign cell_row_new = val_q ? (rd_data | cell_mask) : (rd_data & ~cell_mask);

  // row memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    rd_data <= grid_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (cnt == CNT_W'(GRID_ROWS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          priority if (req_type == REQ_WRITE || req_type == REQ_READ) begin
            state_next = ST_CELL_RD;
          end else if (req_type == REQ_GEN) begin
            state_next = ST_GEN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_CELL_RD:  state_next = ST_CELL_UPD;
      ST_CELL_UPD: state_next = ST_DONE;
      ST_GEN: begin
        if (cnt == CNT_W'(GRID_ROWS + 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    req_stall = 1'b1;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt[ROW_W-1:0];
      end
      ST_IDLE: begin
        req_stall = 1'b0;
      end
      ST_CELL_RD: begin
        rd_addr = cell_inside ? ROW_W'(row_q) : '0;
      end
      ST_CELL_UPD: begin
        wr_en   = cell_inside && (req_type_q == REQ_WRITE);
        wr_addr = ROW_W'(row_q);
        wr_data = cell_row_new;
      end
      ST_GEN: begin
        if (cnt < CNT_W'(GRID_ROWS)) rd_addr = cnt[ROW_W-1:0];
        wr_en   = (cnt >= CNT_W'(2));
        wr_addr = gen_row[ROW_W-1:0];
        wr_data = next_row;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: cnt <= (state_next == ST_IDLE) ? '0 : cnt + CNT_W'(1);
        ST_GEN:   cnt <= cnt + CNT_W'(1);
        default:  cnt <= '0;
      endcase
      if (state == ST_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_q <= req_type;
      row_q      <= cell_row;
      col_q      <= cell_col;
      val_q      <= cell_value;
      rd_bit     <= 1'b0;
    end
    if (state == ST_CELL_UPD) begin
      rd_bit <= cell_inside && (req_type_q == REQ_READ) && cell_shift[0];
    end
    if (state == ST_GEN) begin
      if (cnt == CNT_W'(1)) begin
        above <= '0;
        cur   <= rd_data;
      end else begin
        above <= cur;
        cur   <= below;
      end
    end
    if (state == ST_DONE && rsp_free) begin
      read_value     <= rd_bit;
      completed_type <= req_type_q;
    end
  end

  `LGE_ASSERT_NXT(a_gen_start, accept && req_type == REQ_GEN, state == ST_GEN && cnt == '0)
  `LGE_ASSERT_IMP(a_rd_zero, rsp_valid && completed_type != REQ_READ, !read_value)
  `LGE_ASSERT_IMP(a_wr_state, wr_en, state == ST_CLEAR || state == ST_CELL_UPD || state == ST_GEN)
  `LGE_ASSERT_IMP(a_gen_cnt, state == ST_GEN, cnt <= CNT_W'(GRID_ROWS + 1))

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid generation engine testbench
// Sends cell writes, cell reads, generation steps and the unused request code
// through the valid/stall request port. A local copy of the grid predicts
// every completion, and each response transfer is checked in order. Random
// idle gaps on both sides, one long response hold-off that backs up the
// request port, and a final stretch with no idling.
// ----------------------------------------------------------------------------
module tb;
  import lge_pkg::*;

  localparam int GRID_ROWS       = 32;
  localparam int GRID_COLS       = 32;
  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 2 * GRID_ROWS + 8;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic                  read_value;
    logic [REQ_TYPE_W-1:0] completed_type;
  } completion_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  req_valid  = 1'b0;
  logic [REQ_TYPE_W-1:0] req_type   = REQ_WRITE;
  logic [CELL_POS_W-1:0] cell_row   = '0;
  logic [CELL_POS_W-1:0] cell_col   = '0;
  logic                  cell_value = 1'b0;
  logic                  rsp_stall  = 1'b0;
  logic                  req_stall;
  logic                  rsp_valid;
  logic                  read_value;
  logic [REQ_TYPE_W-1:0] completed_type;

  logic [GRID_COLS-1:0] grid_model [GRID_ROWS];
  completion_t          expected_completions [$];

  int mismatch_count   = 0;
  int items_sent       = 0;
  int done_count [4]   = '{0, 0, 0, 0};
  int stall_streak     = 0;
  int max_stall_streak = 0;
  bit gaps_on          = 1'b0;
  bit stalls_on        = 1'b0;
  bit hold_off_req     = 1'b0;

  life_grid_generation_engine_unit #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .cell_row      (cell_row),
    .cell_col      (cell_col),
    .cell_value    (cell_value),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .read_value    (read_value),
    .completed_type(completed_type)
  );

  always #5 clk = ~clk;

  function automatic int live_at(logic [GRID_COLS-1:0] bits, int c);
    if (c < 0 || c >= GRID_COLS) return 0;
    return int'(bits[c]);
  endfunction

  // B3/S23 over the whole grid, edges dead
  function automatic void advance_grid_model();
    logic [GRID_COLS-1:0] row_above, row_cur, row_below, row_next;
    int nbrs;
    row_above = '0;
    for (int r = 0; r < GRID_ROWS; r++) begin
      row_cur   = grid_model[r];
      row_below = (r + 1 < GRID_ROWS) ? grid_model[r + 1] : '0;
      for (int c = 0; c < GRID_COLS; c++) begin
        nbrs = live_at(row_above, c - 1) + live_at(row_above, c) + live_at(row_above, c + 1)
             + live_at(row_cur, c - 1) + live_at(row_cur, c + 1)
             + live_at(row_below, c - 1) + live_at(row_below, c) + live_at(row_below, c + 1);
        row_next[c] = (nbrs == NBR_BIRTH) || (row_cur[c] && nbrs == NBR_KEEP);
      end
      grid_model[r] = row_next;
      row_above     = row_cur;
    end
  endfunction

  function automatic completion_t predict_completion(logic [REQ_TYPE_W-1:0] kind,
                                                     logic [CELL_POS_W-1:0] row,
                                                     logic [CELL_POS_W-1:0] col,
                                                     logic val);
    completion_t c;
    bit on_grid;
    on_grid          = (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLS);
    c.read_value     = 1'b0;
    c.completed_type = kind;
    case (kind)
      REQ_WRITE: begin
        if (on_grid) grid_model[row][col] = val;
      end
      REQ_GEN: begin
        advance_grid_model();
      end
      REQ_READ: begin
        if (on_grid) c.read_value = grid_model[row][col];
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  task automatic note_mismatch(string what, logic [1:0] want_v, logic [1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %b, got %b", $time, what, want_v, got_v);
  endtask

  // request side: predict on every accepted transfer
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall)
      expected_completions.push_back(
        predict_completion(req_type, cell_row, cell_col, cell_value));
    if (!rst && req_valid && req_stall) begin
      stall_streak++;
      if (stall_streak > max_stall_streak) max_stall_streak = stall_streak;
    end else begin
      stall_streak = 0;
    end
  end

  // response side: compare with oldest expectation
  always @(posedge clk) begin
    completion_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_completions.size() == 0) begin
        note_mismatch("unexpected completion, completed_type", 2'bxx, completed_type);
      end else begin
        want = expected_completions.pop_front();
        if (read_value !== want.read_value)
          note_mismatch("read_value", {1'b0, want.read_value}, {1'b0, read_value});
        if (completed_type !== want.completed_type)
          note_mismatch("completed_type", want.completed_type, completed_type);
        done_count[want.completed_type]++;
      end
    end
  end

  // response stall: random bursts, or one long hold-off on request
  always begin
    @(posedge clk);
    if (hold_off_req) begin
      rsp_stall <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      rsp_stall <= 1'b0;
      hold_off_req = 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      rsp_stall <= 1'b1;
      repeat ($urandom_range(1, 18)) @(posedge clk);
      rsp_stall <= 1'b0;
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  task automatic send_req(input logic [REQ_TYPE_W-1:0] kind, input logic [CELL_POS_W-1:0] row,
                          input logic [CELL_POS_W-1:0] col, input logic val);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= kind;
    cell_row   <= row;
    cell_col   <= col;
    cell_value <= val;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_item(input logic [REQ_TYPE_W-1:0] kind);
    send_req(kind, CELL_POS_W'($urandom_range(0, 31)), CELL_POS_W'($urandom_range(0, 31)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic test_directed_cases();
    // three live cells at a corner grow into a still block
    send_req(REQ_WRITE, 0, 0, 1'b1);
    send_req(REQ_WRITE, 0, 1, 1'b1);
    send_req(REQ_WRITE, 1, 0, 1'b1);
    send_req(REQ_WRITE, 31, 31, 1'b1);
    send_req(REQ_WRITE, 31, 30, 1'b1);
    send_req(REQ_WRITE, 30, 31, 1'b1);
    // lone cell at the far column dies
    send_req(REQ_WRITE, 0, 31, 1'b1);
    send_req(REQ_WRITE, 15, 15, 1'b1);
    send_req(REQ_WRITE, 15, 15, 1'b0);
    send_req(REQ_READ, 0, 0, 1'b1);
    send_req(REQ_READ, 15, 15, 1'b0);
    // unused code must not touch the grid
    send_req(REQ_UNUSED, 31, 31, 1'b0);
    send_req(REQ_UNUSED, 0, 0, 1'b1);
    send_req(REQ_GEN, 31, 31, 1'b1);
    send_req(REQ_READ, 1, 1, 1'b0);
    send_req(REQ_READ, 30, 30, 1'b1);
    send_req(REQ_READ, 0, 31, 1'b0);
    send_req(REQ_READ, 31, 31, 1'b1);
    send_req(REQ_GEN, 0, 0, 1'b0);
    send_req(REQ_READ, 0, 0, 1'b0);
  endtask

  // patterns written into a random window, stepped, then probed around it;
  // some episodes are plain noise with any request code
  task automatic test_random_patterns(input int target, input bit with_idling);
    int r0, c0, h, w, density, rr, cc;
    while (items_sent < target) begin
      gaps_on   = with_idling && ($urandom_range(0, 4) != 0);
      stalls_on = with_idling && ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) < 8) begin
        r0      = $urandom_range(0, GRID_ROWS - 1);
        c0      = $urandom_range(0, GRID_COLS - 1);
        h       = $urandom_range(3, 6);
        w       = $urandom_range(3, 6);
        density = $urandom_range(20, 60);
        for (int i = 0; i < h; i++)
          for (int j = 0; j < w; j++)
            if (r0 + i < GRID_ROWS && c0 + j < GRID_COLS)
              send_req(REQ_WRITE, CELL_POS_W'(r0 + i), CELL_POS_W'(c0 + j),
                       $urandom_range(0, 99) < density);
        repeat ($urandom_range(1, 4)) send_random_item(REQ_GEN);
        repeat ($urandom_range(6, 12)) begin
          rr = r0 + $urandom_range(0, h + 1) - 1;
          cc = c0 + $urandom_range(0, w + 1) - 1;
          rr = (rr < 0) ? 0 : (rr >= GRID_ROWS) ? GRID_ROWS - 1 : rr;
          cc = (cc < 0) ? 0 : (cc >= GRID_COLS) ? GRID_COLS - 1 : cc;
          send_req(REQ_READ, CELL_POS_W'(rr), CELL_POS_W'(cc), 1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_random_item(REQ_TYPE_W'($urandom_range(0, 3)));
      end
    end
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_result_hold_off();
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) send_random_item(REQ_TYPE_W'($urandom_range(0, 3)));
  endtask

  initial begin
    int waited;
    foreach (grid_model[r]) grid_model[r] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_patterns(780, 1'b1);
    test_result_hold_off();
    test_random_patterns(1150, 1'b0);

    req_valid <= 1'b0;
    waited = 0;
    while (expected_completions.size() != 0 && waited < IDLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_completions.size() != 0) begin
      $display("%0d expected completions never arrived", expected_completions.size());
      mismatch_count += expected_completions.size();
    end

    $display("checked %0d writes, %0d generation steps, %0d reads, %0d unused-code requests",
             done_count[REQ_WRITE], done_count[REQ_GEN], done_count[REQ_READ],
             done_count[REQ_UNUSED]);
    $display("request port backed up for up to %0d cycles; %0d mismatches",
             max_stall_streak, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lge_pkg.sv
rtl/life_grid_generation_engine_unit.sv
tb/tb.sv
